>>> sv/sbhs_pkg.sv
// ----------------------------------------------------------------------------
// sbhs_pkg
// Shared types, codes and constants of the serial bootloader host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbhs_pkg;

    localparam int MAX_READ_BYTES_DEF = 256;
    localparam int Q_DEPTH            = 4;

    localparam logic [7:0] ACK_BYTE  = 8'h79;
    localparam logic [7:0] INIT_BYTE = 8'h7F;
    localparam logic [7:0] GET_CODE  = 8'h00;

    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_BYTE = 2'd2;

    typedef enum logic [1:0] {
        KIND_TX,
        KIND_READ,
        KIND_DONE,
        KIND_FAIL
    } t_kind;

    typedef enum logic [1:0] {
        RSN_NACK,
        RSN_ALIGN,
        RSN_ID_LEN,
        RSN_BUSY
    } t_reason;

    typedef enum logic [4:0] {
        PH_IDLE, PH_INIT_ACK, PH_GET_ACK, PH_GET_LEN, PH_GET_DATA, PH_GET_END,
        PH_GVR_ACK, PH_GVR_V, PH_GVR_O1, PH_GVR_O2, PH_GVR_END,
        PH_GID_ACK, PH_GID_LEN, PH_GID_HI, PH_GID_LO, PH_GID_END,
        PH_RM_ACK1, PH_RM_ACK2, PH_RM_ACK3, PH_RM_DATA
    } t_phase;

    typedef enum logic [2:0] {
        OP_TX_ONE,
        OP_TX_PAIR,
        OP_TX_ADDR,
        OP_DONE,
        OP_FAIL,
        OP_DATA,
        OP_DATA_DONE
    } t_op;

    typedef struct packed {
        logic [7:0]  boot_version;
        logic [7:0]  protocol_version;
        logic [15:0] options;
        logic [15:0] product_id;
    } t_info;

    typedef struct packed {
        t_op         op;
        logic [7:0]  value;
        logic [31:0] address;
        t_reason     reason;
        t_info       info;
    } t_desc;

    function automatic logic [2:0] op_len(t_op op);
        logic [2:0] n;
        case (op)
            OP_TX_PAIR:   n = 3'd2;
            OP_TX_ADDR:   n = 3'd5;
            OP_DATA_DONE: n = 3'd2;
            default:      n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> sv/sbhs_if.sv
// ----------------------------------------------------------------------------
// sbhs_if
// Request and result channels of the serial bootloader host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbhs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  rx_byte;
    logic [31:0] address;
    logic [8:0]  read_length;

    modport source (output valid, req_type, rx_byte, address, read_length, input ready);
    modport sink   (input valid, req_type, rx_byte, address, read_length, output ready);
endinterface

interface sbhs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic        last;
    logic [7:0]  boot_version;
    logic [7:0]  protocol_version;
    logic [7:0]  option_one;
    logic [7:0]  option_two;
    logic [15:0] product_id;
    logic [1:0]  fail_reason;

    modport source (output valid, kind, byte_value, last, boot_version, protocol_version,
                    option_one, option_two, product_id, fail_reason, input ready);
    modport sink   (input valid, kind, byte_value, last, boot_version, protocol_version,
                    option_one, option_two, product_id, fail_reason, output ready);
endinterface

`default_nettype wire

>>> sv/serial_bootloader_host_sequencer.sv
// ----------------------------------------------------------------------------
// serial_bootloader_host_sequencer
// Host side of a serial bootloader: init, GET, GVR, GID and read memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      carries
//  i_req    in   valid/ready    req_type, rx_byte, address, read_length
//  o_res    out  valid/ready    kind, byte_value, last, saved ids, fail_reason
//
//  A request is taken whenever the descriptor queue has room. Each request
//  yields zero to five result items, one per cycle from the expander into
//  the output register while the output is not stalled; the expander sets
//  the sustained rate. Reset is synchronous; no clearing pass follows.
//  A stalled output holds its item while the queue keeps taking requests.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bootloader_host_sequencer #(
    parameter int MAX_READ_BYTES = sbhs_pkg::MAX_READ_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbhs_req_if.sink   i_req,
    sbhs_res_if.source o_res
);

    logic            w_push;
    sbhs_pkg::t_desc w_push_desc;
    logic            w_space;
    logic            w_q_valid;
    sbhs_pkg::t_desc w_q_desc;
    logic            w_pop;

    sbhs_front #(
        .MAX_READ_BYTES (MAX_READ_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_space (w_space),
        .o_push  (w_push),
        .o_desc  (w_push_desc)
    );

    sbhs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc),
        .i_pop   (w_pop)
    );

    sbhs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_desc  (w_q_desc),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

>>> sv/sbhs_front.sv
// ----------------------------------------------------------------------------
// sbhs_front
// Accepts requests, runs the bootloader phase machine and emits one
// result descriptor per item that has results.
// ----------------------------------------------------------------------------
`default_nettype none

module sbhs_front #(
    parameter int MAX_READ_BYTES = sbhs_pkg::MAX_READ_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sbhs_req_if.sink         i_req,
    input  wire logic        i_space,
    output logic             o_push,
    output sbhs_pkg::t_desc  o_desc
);

    sbhs_pkg::t_phase r_phase, n_phase;
    logic [8:0]       r_byte_count, n_byte_count;
    logic [3:0]       r_get_index, n_get_index;
    logic [7:0]       r_code_gvr, n_code_gvr;
    logic [7:0]       r_code_gid, n_code_gid;
    logic [7:0]       r_code_read, n_code_read;
    sbhs_pkg::t_info  r_info, n_info;
    logic [31:0]      r_address, n_address;
    logic [8:0]       r_length, n_length;
    logic             r_initialized, n_initialized;

    logic       w_acc;
    logic       w_ack;
    logic       w_ack_phase;
    logic       w_nack;
    logic [7:0] w_b;
    logic [8:0] w_len;
    logic [8:0] w_len_m1;

    assign i_req.ready = i_space;
    assign w_acc       = i_req.valid & i_space;
    assign w_b         = i_req.rx_byte;
    assign w_ack       = (w_b == sbhs_pkg::ACK_BYTE);
    assign w_ack_phase = r_phase inside {sbhs_pkg::PH_INIT_ACK, sbhs_pkg::PH_GET_ACK,
                                         sbhs_pkg::PH_GET_END, sbhs_pkg::PH_GVR_ACK,
                                         sbhs_pkg::PH_GVR_END, sbhs_pkg::PH_GID_ACK,
                                         sbhs_pkg::PH_GID_END, sbhs_pkg::PH_RM_ACK1,
                                         sbhs_pkg::PH_RM_ACK2, sbhs_pkg::PH_RM_ACK3};
    assign w_nack      = w_ack_phase & ~w_ack;
    assign w_len_m1    = r_length - 9'd1;

    always_comb begin
        if (i_req.read_length == 9'd0) begin
            w_len = 9'd1;
        end else if (i_req.read_length > 9'(MAX_READ_BYTES)) begin
            w_len = 9'(MAX_READ_BYTES);
        end else begin
            w_len = i_req.read_length;
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_get_index   = r_get_index;
        n_code_gvr    = r_code_gvr;
        n_code_gid    = r_code_gid;
        n_code_read   = r_code_read;
        n_info        = r_info;
        n_address     = r_address;
        n_length      = r_length;
        n_initialized = r_initialized;
        if (w_acc) begin
            case (i_req.req_type)
                sbhs_pkg::REQ_INIT: begin
                    if (r_phase == sbhs_pkg::PH_IDLE) begin
                        n_code_gvr    = '0;
                        n_code_gid    = '0;
                        n_code_read   = '0;
                        n_info        = '0;
                        n_initialized = 1'b0;
                        n_byte_count  = '0;
                        n_get_index   = '0;
                        n_phase       = sbhs_pkg::PH_INIT_ACK;
                    end
                end
                sbhs_pkg::REQ_READ: begin
                    if (r_phase == sbhs_pkg::PH_IDLE && r_initialized
                            && i_req.address[1:0] == 2'b00) begin
                        n_address = i_req.address;
                        n_length  = w_len;
                        n_phase   = sbhs_pkg::PH_RM_ACK1;
                    end
                end
                sbhs_pkg::REQ_BYTE: begin
                    if (w_nack) begin
                        n_phase = sbhs_pkg::PH_IDLE;
                        if (r_phase < sbhs_pkg::PH_RM_ACK1) begin
                            n_initialized = 1'b0;
                        end
                    end else begin
                        case (r_phase)
                            sbhs_pkg::PH_INIT_ACK: n_phase = sbhs_pkg::PH_GET_ACK;
                            sbhs_pkg::PH_GET_ACK:  n_phase = sbhs_pkg::PH_GET_LEN;
                            sbhs_pkg::PH_GET_LEN: begin
                                n_byte_count = {1'b0, w_b} + 9'd1;
                                n_get_index  = '0;
                                n_phase      = sbhs_pkg::PH_GET_DATA;
                            end
                            sbhs_pkg::PH_GET_DATA: begin
                                if (r_get_index == 4'd0) n_info.boot_version = w_b;
                                if (r_get_index == 4'd2) n_code_gvr = w_b;
                                if (r_get_index == 4'd3) n_code_gid = w_b;
                                if (r_get_index == 4'd4) n_code_read = w_b;
                                if (r_get_index < 4'd12) n_get_index = r_get_index + 4'd1;
                                n_byte_count = r_byte_count - 9'd1;
                                if (r_byte_count == 9'd1) n_phase = sbhs_pkg::PH_GET_END;
                            end
                            sbhs_pkg::PH_GET_END: n_phase = sbhs_pkg::PH_GVR_ACK;
                            sbhs_pkg::PH_GVR_ACK: n_phase = sbhs_pkg::PH_GVR_V;
                            sbhs_pkg::PH_GVR_V: begin
                                n_info.protocol_version = w_b;
                                n_phase = sbhs_pkg::PH_GVR_O1;
                            end
                            sbhs_pkg::PH_GVR_O1: begin
                                n_info.options[15:8] = w_b;
                                n_phase = sbhs_pkg::PH_GVR_O2;
                            end
                            sbhs_pkg::PH_GVR_O2: begin
                                n_info.options[7:0] = w_b;
                                n_phase = sbhs_pkg::PH_GVR_END;
                            end
                            sbhs_pkg::PH_GVR_END: n_phase = sbhs_pkg::PH_GID_ACK;
                            sbhs_pkg::PH_GID_ACK: n_phase = sbhs_pkg::PH_GID_LEN;
                            sbhs_pkg::PH_GID_LEN: begin
                                if (w_b != 8'd1) begin
                                    n_phase       = sbhs_pkg::PH_IDLE;
                                    n_initialized = 1'b0;
                                end else begin
                                    n_phase = sbhs_pkg::PH_GID_HI;
                                end
                            end
                            sbhs_pkg::PH_GID_HI: begin
                                n_info.product_id[15:8] = w_b;
                                n_phase = sbhs_pkg::PH_GID_LO;
                            end
                            sbhs_pkg::PH_GID_LO: begin
                                n_info.product_id[7:0] = w_b;
                                n_phase = sbhs_pkg::PH_GID_END;
                            end
                            sbhs_pkg::PH_GID_END: begin
                                n_initialized = 1'b1;
                                n_phase       = sbhs_pkg::PH_IDLE;
                            end
                            sbhs_pkg::PH_RM_ACK1: n_phase = sbhs_pkg::PH_RM_ACK2;
                            sbhs_pkg::PH_RM_ACK2: n_phase = sbhs_pkg::PH_RM_ACK3;
                            sbhs_pkg::PH_RM_ACK3: begin
                                n_byte_count = r_length;
                                n_phase      = sbhs_pkg::PH_RM_DATA;
                            end
                            sbhs_pkg::PH_RM_DATA: begin
                                n_byte_count = r_byte_count - 9'd1;
                                if (r_byte_count == 9'd1) n_phase = sbhs_pkg::PH_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // descriptor
    always_comb begin
        o_push         = 1'b0;
        o_desc.op      = sbhs_pkg::OP_DONE;
        o_desc.value   = '0;
        o_desc.address = r_address;
        o_desc.reason  = sbhs_pkg::RSN_NACK;
        o_desc.info    = n_info;
        if (w_acc) begin
            case (i_req.req_type)
                sbhs_pkg::REQ_INIT: begin
                    o_push = 1'b1;
                    if (r_phase != sbhs_pkg::PH_IDLE) begin
                        o_desc.op     = sbhs_pkg::OP_FAIL;
                        o_desc.reason = sbhs_pkg::RSN_BUSY;
                    end else begin
                        o_desc.op    = sbhs_pkg::OP_TX_ONE;
                        o_desc.value = sbhs_pkg::INIT_BYTE;
                    end
                end
                sbhs_pkg::REQ_READ: begin
                    o_push = 1'b1;
                    if (r_phase != sbhs_pkg::PH_IDLE || !r_initialized) begin
                        o_desc.op     = sbhs_pkg::OP_FAIL;
                        o_desc.reason = sbhs_pkg::RSN_BUSY;
                    end else if (i_req.address[1:0] != 2'b00) begin
                        o_desc.op     = sbhs_pkg::OP_FAIL;
                        o_desc.reason = sbhs_pkg::RSN_ALIGN;
                    end else begin
                        o_desc.op    = sbhs_pkg::OP_TX_PAIR;
                        o_desc.value = r_code_read;
                    end
                end
                sbhs_pkg::REQ_BYTE: begin
                    if (w_nack) begin
                        o_push        = 1'b1;
                        o_desc.op     = sbhs_pkg::OP_FAIL;
                        o_desc.reason = sbhs_pkg::RSN_NACK;
                    end else begin
                        case (r_phase)
                            sbhs_pkg::PH_INIT_ACK: begin
                                o_push       = 1'b1;
                                o_desc.op    = sbhs_pkg::OP_TX_PAIR;
                                o_desc.value = sbhs_pkg::GET_CODE;
                            end
                            sbhs_pkg::PH_GET_END: begin
                                o_push       = 1'b1;
                                o_desc.op    = sbhs_pkg::OP_TX_PAIR;
                                o_desc.value = r_code_gvr;
                            end
                            sbhs_pkg::PH_GVR_END: begin
                                o_push       = 1'b1;
                                o_desc.op    = sbhs_pkg::OP_TX_PAIR;
                                o_desc.value = r_code_gid;
                            end
                            sbhs_pkg::PH_GID_LEN: begin
                                if (w_b != 8'd1) begin
                                    o_push        = 1'b1;
                                    o_desc.op     = sbhs_pkg::OP_FAIL;
                                    o_desc.reason = sbhs_pkg::RSN_ID_LEN;
                                end
                            end
                            sbhs_pkg::PH_GID_END: begin
                                o_push    = 1'b1;
                                o_desc.op = sbhs_pkg::OP_DONE;
                            end
                            sbhs_pkg::PH_RM_ACK1: begin
                                o_push    = 1'b1;
                                o_desc.op = sbhs_pkg::OP_TX_ADDR;
                            end
                            sbhs_pkg::PH_RM_ACK2: begin
                                o_push       = 1'b1;
                                o_desc.op    = sbhs_pkg::OP_TX_PAIR;
                                o_desc.value = w_len_m1[7:0];
                            end
                            sbhs_pkg::PH_RM_DATA: begin
                                o_push       = 1'b1;
                                o_desc.value = w_b;
                                o_desc.op    = (r_byte_count == 9'd1) ? sbhs_pkg::OP_DATA_DONE
                                                                       : sbhs_pkg::OP_DATA;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sbhs_pkg::PH_IDLE;
            r_byte_count  <= '0;
            r_get_index   <= '0;
            r_code_gvr    <= '0;
            r_code_gid    <= '0;
            r_code_read   <= '0;
            r_info        <= '0;
            r_address     <= '0;
            r_length      <= '0;
            r_initialized <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_get_index   <= n_get_index;
            r_code_gvr    <= n_code_gvr;
            r_code_gid    <= n_code_gid;
            r_code_read   <= n_code_read;
            r_info        <= n_info;
            r_address     <= n_address;
            r_length      <= n_length;
            r_initialized <= n_initialized;
        end
    end

endmodule

`default_nettype wire

>>> sv/sbhs_queue.sv
// ----------------------------------------------------------------------------
// sbhs_queue
// Short descriptor queue between the phase machine and the result expander.
// ----------------------------------------------------------------------------
`default_nettype none

module sbhs_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sbhs_pkg::t_desc  i_desc,
    output logic                  o_space,
    output logic                  o_valid,
    output sbhs_pkg::t_desc       o_desc,
    input  wire logic             i_pop
);

    localparam int AW = $clog2(sbhs_pkg::Q_DEPTH);

    sbhs_pkg::t_desc r_mem [sbhs_pkg::Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [AW:0]     r_count, n_count;
    logic            w_push;
    logic            w_pop;

    assign o_space = (r_count != (AW+1)'(sbhs_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign w_push  = i_push & o_space;
    assign w_pop   = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(sbhs_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(sbhs_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> sv/sbhs_back.sv
// ----------------------------------------------------------------------------
// sbhs_back
// Expands each descriptor into its result items, one per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbhs_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire sbhs_pkg::t_desc  i_desc,
    output logic                  o_pop,
    sbhs_res_if.source            o_res
);

    logic            r_valid;
    logic [2:0]      r_step;
    logic [1:0]      r_kind;
    logic [7:0]      r_value;
    logic            r_last;
    logic [1:0]      r_reason;
    sbhs_pkg::t_info r_info;

    logic            w_load;
    logic [2:0]      w_len;
    logic            w_last;
    sbhs_pkg::t_kind w_kind;
    logic [7:0]      w_value;
    logic [1:0]      w_reason;
    logic [31:0]     w_a;

    assign w_load = ~r_valid | o_res.ready;
    assign w_len  = sbhs_pkg::op_len(i_desc.op);
    assign w_last = (r_step == w_len - 3'd1);
    assign o_pop  = w_load & i_valid & w_last;
    assign w_a    = i_desc.address;

    always_comb begin
        w_kind   = sbhs_pkg::KIND_TX;
        w_value  = '0;
        w_reason = '0;
        case (i_desc.op)
            sbhs_pkg::OP_TX_ONE: begin
                w_value = i_desc.value;
            end
            sbhs_pkg::OP_TX_PAIR: begin
                w_value = (r_step == 3'd0) ? i_desc.value : ~i_desc.value;
            end
            sbhs_pkg::OP_TX_ADDR: begin
                case (r_step)
                    3'd0:    w_value = w_a[31:24];
                    3'd1:    w_value = w_a[23:16];
                    3'd2:    w_value = w_a[15:8];
                    3'd3:    w_value = w_a[7:0];
                    default: w_value = w_a[31:24] ^ w_a[23:16] ^ w_a[15:8] ^ w_a[7:0];
                endcase
            end
            sbhs_pkg::OP_FAIL: begin
                w_kind   = sbhs_pkg::KIND_FAIL;
                w_reason = i_desc.reason;
            end
            sbhs_pkg::OP_DATA: begin
                w_kind  = sbhs_pkg::KIND_READ;
                w_value = i_desc.value;
            end
            sbhs_pkg::OP_DATA_DONE: begin
                if (r_step == 3'd0) begin
                    w_kind  = sbhs_pkg::KIND_READ;
                    w_value = i_desc.value;
                end else begin
                    w_kind = sbhs_pkg::KIND_DONE;
                end
            end
            default: begin
                w_kind = sbhs_pkg::KIND_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (w_load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_step <= w_last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_kind   <= w_kind;
            r_value  <= w_value;
            r_last   <= w_last;
            r_reason <= w_reason;
            r_info   <= i_desc.info;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.kind             = r_kind;
    assign o_res.byte_value       = r_value;
    assign o_res.last             = r_last;
    assign o_res.boot_version     = r_info.boot_version;
    assign o_res.protocol_version = r_info.protocol_version;
    assign o_res.option_one       = r_info.options[15:8];
    assign o_res.option_two       = r_info.options[7:0];
    assign o_res.product_id       = r_info.product_id;
    assign o_res.fail_reason      = r_reason;

endmodule

`default_nettype wire

>>> sv/sbhs_checker.sv
// ----------------------------------------------------------------------------
// sbhs_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbhs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_kind,
    input wire logic [7:0] i_byte_value,
    input wire logic       i_last,
    input wire logic [1:0] i_fail_reason
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_end_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == sbhs_pkg::KIND_DONE || i_kind == sbhs_pkg::KIND_FAIL)
        |-> i_last)
        else $error("completion or failure not last");

    a_end_no_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == sbhs_pkg::KIND_DONE || i_kind == sbhs_pkg::KIND_FAIL)
        |-> i_byte_value == 8'd0)
        else $error("completion or failure carries a byte");

    a_reason_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != sbhs_pkg::KIND_FAIL |-> i_fail_reason == 2'd0)
        else $error("reason set outside failure");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind serial_bootloader_host_sequencer sbhs_checker u_sbhs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_kind        (o_res.kind),
    .i_byte_value  (o_res.byte_value),
    .i_last        (o_res.last),
    .i_fail_reason (o_res.fail_reason)
);

`default_nettype wire

>>> sim/sbhs_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbhs_result_checker
// Watches the request and result channels of the host sequencer. Every
// accepted request runs through a cycle-free model of the handshake
// sequencer; the result items it yields are queued and each accepted result
// is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module sbhs_result_checker
    import sbhs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sbhs_req_if  req_ch,
    sbhs_res_if  res_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    localparam int MAX_PRINTED      = 40;
    localparam int MAX_STEP_RESULTS = 5;
    localparam int CODE_SLOTS       = 11;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic        last;
        logic [7:0]  boot_version;
        logic [7:0]  protocol_version;
        logic [7:0]  option_one;
        logic [7:0]  option_two;
        logic [15:0] product_id;
        t_reason     reason;
    } t_expected;

    t_phase      seq_phase;
    logic [8:0]  bytes_left;
    int          code_index;
    logic [7:0]  cmd_codes [CODE_SLOTS];
    logic [7:0]  saved_boot;
    logic [7:0]  saved_proto;
    logic [15:0] saved_options;
    logic [15:0] saved_pid;
    logic [31:0] read_addr;
    logic [8:0]  read_len;
    logic        link_up;

    t_expected   step_results[$];
    t_expected   expected_results[$];
    int          err_count;
    int          checked_count;

    function automatic void clear_learned();
        foreach (cmd_codes[i]) cmd_codes[i] = 8'h00;
        saved_boot    = 8'h00;
        saved_proto   = 8'h00;
        saved_options = 16'h0000;
        saved_pid     = 16'h0000;
        link_up       = 1'b0;
        bytes_left    = 9'd0;
        code_index    = 0;
    endfunction

    function automatic void reset_model();
        clear_learned();
        seq_phase = PH_IDLE;
        read_addr = 32'h0;
        read_len  = 9'd0;
    endfunction

    function automatic void emit(t_kind k, logic [7:0] v, t_reason r);
        t_expected e;
        if (step_results.size() >= MAX_STEP_RESULTS) return;
        e.kind             = k;
        e.value            = v;
        e.last             = 1'b0;
        e.boot_version     = saved_boot;
        e.protocol_version = saved_proto;
        e.option_one       = saved_options[15:8];
        e.option_two       = saved_options[7:0];
        e.product_id       = saved_pid;
        e.reason           = r;
        step_results.push_back(e);
    endfunction

    function automatic void send_code(logic [7:0] code);
        emit(KIND_TX, code, RSN_NACK);
        emit(KIND_TX, 8'hFF - code, RSN_NACK);
    endfunction

    function automatic void abort_sequence(t_reason r);
        if (seq_phase < PH_RM_ACK1) link_up = 1'b0;
        seq_phase = PH_IDLE;
        emit(KIND_FAIL, 8'h00, r);
    endfunction

    function automatic void take_rx_byte(logic [7:0] b);
        logic       is_ack;
        logic [7:0] csum;
        logic [7:0] len_code;
        is_ack = (b == ACK_BYTE);
        case (seq_phase)
            PH_INIT_ACK: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    send_code(GET_CODE);
                    seq_phase = PH_GET_ACK;
                end
            end
            PH_GET_ACK: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else seq_phase = PH_GET_LEN;
            end
            PH_GET_LEN: begin
                bytes_left = {1'b0, b} + 9'd1;
                code_index = 0;
                seq_phase  = PH_GET_DATA;
            end
            PH_GET_DATA: begin
                if (code_index == 0) saved_boot = b;
                else if (code_index <= CODE_SLOTS) cmd_codes[code_index - 1] = b;
                if (code_index <= CODE_SLOTS) code_index++;
                bytes_left = bytes_left - 9'd1;
                if (bytes_left == 9'd0) seq_phase = PH_GET_END;
            end
            PH_GET_END: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    send_code(cmd_codes[1]);
                    seq_phase = PH_GVR_ACK;
                end
            end
            PH_GVR_ACK: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else seq_phase = PH_GVR_V;
            end
            PH_GVR_V: begin
                saved_proto = b;
                seq_phase   = PH_GVR_O1;
            end
            PH_GVR_O1: begin
                saved_options[15:8] = b;
                seq_phase           = PH_GVR_O2;
            end
            PH_GVR_O2: begin
                saved_options[7:0] = b;
                seq_phase          = PH_GVR_END;
            end
            PH_GVR_END: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    send_code(cmd_codes[2]);
                    seq_phase = PH_GID_ACK;
                end
            end
            PH_GID_ACK: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else seq_phase = PH_GID_LEN;
            end
            PH_GID_LEN: begin
                if (b != 8'd1) abort_sequence(RSN_ID_LEN);
                else seq_phase = PH_GID_HI;
            end
            PH_GID_HI: begin
                saved_pid[15:8] = b;
                seq_phase       = PH_GID_LO;
            end
            PH_GID_LO: begin
                saved_pid[7:0] = b;
                seq_phase      = PH_GID_END;
            end
            PH_GID_END: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    link_up   = 1'b1;
                    seq_phase = PH_IDLE;
                    emit(KIND_DONE, 8'h00, RSN_NACK);
                end
            end
            PH_RM_ACK1: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    csum = read_addr[31:24] ^ read_addr[23:16] ^ read_addr[15:8]
                         ^ read_addr[7:0];
                    emit(KIND_TX, read_addr[31:24], RSN_NACK);
                    emit(KIND_TX, read_addr[23:16], RSN_NACK);
                    emit(KIND_TX, read_addr[15:8], RSN_NACK);
                    emit(KIND_TX, read_addr[7:0], RSN_NACK);
                    emit(KIND_TX, csum, RSN_NACK);
                    seq_phase = PH_RM_ACK2;
                end
            end
            PH_RM_ACK2: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    len_code = read_len[7:0] - 8'd1;
                    emit(KIND_TX, len_code, RSN_NACK);
                    emit(KIND_TX, 8'hFF - len_code, RSN_NACK);
                    seq_phase = PH_RM_ACK3;
                end
            end
            PH_RM_ACK3: begin
                if (!is_ack) abort_sequence(RSN_NACK);
                else begin
                    bytes_left = read_len;
                    seq_phase  = PH_RM_DATA;
                end
            end
            PH_RM_DATA: begin
                emit(KIND_READ, b, RSN_NACK);
                bytes_left = bytes_left - 9'd1;
                if (bytes_left == 9'd0) begin
                    seq_phase = PH_IDLE;
                    emit(KIND_DONE, 8'h00, RSN_NACK);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_request(logic [1:0] rtype, logic [7:0] rx,
                                            logic [31:0] addr, logic [8:0] len);
        logic [8:0] eff_len;
        t_expected  e;
        step_results.delete();
        case (rtype)
            REQ_INIT: begin
                if (seq_phase != PH_IDLE) emit(KIND_FAIL, 8'h00, RSN_BUSY);
                else begin
                    clear_learned();
                    emit(KIND_TX, INIT_BYTE, RSN_NACK);
                    seq_phase = PH_INIT_ACK;
                end
            end
            REQ_READ: begin
                if (seq_phase != PH_IDLE || !link_up) emit(KIND_FAIL, 8'h00, RSN_BUSY);
                else if (addr[1:0] != 2'b00) emit(KIND_FAIL, 8'h00, RSN_ALIGN);
                else begin
                    eff_len = len;
                    if (eff_len == 9'd0) eff_len = 9'd1;
                    if (eff_len > MAX_READ_BYTES_DEF) eff_len = MAX_READ_BYTES_DEF;
                    read_addr = addr;
                    read_len  = eff_len;
                    send_code(cmd_codes[3]);
                    seq_phase = PH_RM_ACK1;
                end
            end
            REQ_BYTE: take_rx_byte(rx);
            default: ;
        endcase
        for (int i = 0; i < step_results.size(); i++) begin
            e      = step_results[i];
            e.last = (i == step_results.size() - 1);
            expected_results.push_back(e);
        end
    endfunction

    task automatic report(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, int idx, logic [15:0] got,
                               logic [15:0] exp);
        if (got !== exp)
            report($sformatf("result %0d %s got %h expected %h", idx, name, got, exp));
    endtask

    task automatic check_result();
        t_expected e;
        if (expected_results.size() == 0) begin
            report($sformatf("result item with none pending: kind %0d value %h",
                             res_ch.kind, res_ch.byte_value));
            return;
        end
        e = expected_results.pop_front();
        check_field("kind", checked_count, res_ch.kind, e.kind);
        check_field("byte_value", checked_count, res_ch.byte_value, e.value);
        check_field("last", checked_count, res_ch.last, e.last);
        check_field("boot_version", checked_count, res_ch.boot_version, e.boot_version);
        check_field("protocol_version", checked_count, res_ch.protocol_version,
                    e.protocol_version);
        check_field("option_one", checked_count, res_ch.option_one, e.option_one);
        check_field("option_two", checked_count, res_ch.option_two, e.option_two);
        check_field("product_id", checked_count, res_ch.product_id, e.product_id);
        check_field("fail_reason", checked_count, res_ch.fail_reason, e.reason);
        checked_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_results.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) check_result();
            if (req_ch.valid && req_ch.ready)
                predict_request(req_ch.req_type, req_ch.rx_byte, req_ch.address,
                                req_ch.read_length);
        end
        o_errors  <= err_count;
        o_pending <= expected_results.size();
        o_checked <= checked_count;
    end

endmodule

>>> sim/serial_bootloader_host_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_bootloader_host_sequencer_tb
// Plays the target side of the bootloader link: init handshakes with GET,
// GVR and GID replies, memory reads of short and full length, broken
// replies and stray requests, with random pacing on both channels. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module serial_bootloader_host_sequencer_tb;
    import sbhs_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int REQUEST_GOAL     = 330;
    localparam int FULL_READ_ITEMS  = 260;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sbhs_req_if req_ch ();
    sbhs_res_if res_ch ();

    int errors;
    int pending_results;
    int results_checked;
    int requests_sent;
    int inits_completed;
    int reads_started;
    int stall_left;
    int quiet_left;
    int idle_cycles;
    bit link_up;
    bit sender_burst;
    bit hold_off_req;
    bit hold_taken;
    bit drained_once;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    serial_bootloader_host_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    sbhs_result_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .o_errors  (errors),
        .o_pending (pending_results),
        .o_checked (results_checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 7) == 0) return ACK_BYTE;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [7:0] pick_nack();
        logic [7:0] b;
        do b = $urandom_range(0, 255); while (b == ACK_BYTE);
        return b;
    endfunction

    function automatic logic [31:0] aligned_addr();
        logic [31:0] a;
        a      = $urandom();
        a[1:0] = 2'b00;
        return a;
    endfunction

    function automatic logic [31:0] misaligned_addr();
        logic [31:0] a;
        a      = $urandom();
        a[1:0] = $urandom_range(1, 3);
        return a;
    endfunction

    function automatic logic [8:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 8);
        if (r < 97) return $urandom_range(9, 64);
        return $urandom_range(256, 511);
    endfunction

    function automatic int pick_get_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 11;
        if (r < 85) return $urandom_range(0, 10);
        return $urandom_range(12, 24);
    endfunction

    // Receiver pacing: short stalls, a few long ones, quiet windows, one long hold-off.
    always @(posedge i_clk) begin
        if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 299) == 0) quiet_left = $urandom_range(50, 150);
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else if (quiet_left == 0 && $urandom_range(0, 7) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(10, 40);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results pending",
                     idle_cycles, pending_results);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic put_request(logic [1:0] rtype, logic [7:0] rx, logic [31:0] addr,
                               logic [8:0] len);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rtype;
        req_ch.rx_byte     <= rx;
        req_ch.address     <= addr;
        req_ch.read_length <= len;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        requests_sent++;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put_byte(logic [7:0] b);
        put_request(REQ_BYTE, b, $urandom(), $urandom_range(0, 511));
    endtask

    // Stray requests while a sequence runs: refused or ignored.
    task automatic interject();
        int r;
        r = $urandom_range(0, 29);
        if (r == 0) put_request(REQ_INIT, pick_data(), $urandom(), $urandom_range(0, 511));
        else if (r == 1) put_request(REQ_READ, pick_data(), $urandom(), pick_length());
        else if (r == 2) put_request(REQ_NONE, pick_data(), $urandom(), $urandom_range(0, 511));
    endtask

    task automatic answer_ack(bit may_break, output bit ok);
        interject();
        if (may_break && $urandom_range(0, 29) == 0) begin
            put_byte(pick_nack());
            ok = 1'b0;
        end else begin
            put_byte(ACK_BYTE);
            ok = 1'b1;
        end
    endtask

    task automatic run_init(int get_count, bit may_break);
        bit         ok;
        int         i;
        logic [7:0] id_len;
        put_request(REQ_INIT, pick_data(), $urandom(), $urandom_range(0, 511));
        link_up = 1'b0;
        answer_ack(may_break, ok);
        if (!ok) return;
        answer_ack(may_break, ok);
        if (!ok) return;
        put_byte(get_count[7:0]);
        for (i = 0; i <= get_count; i++) begin
            interject();
            put_byte(pick_data());
        end
        answer_ack(may_break, ok);
        if (!ok) return;
        answer_ack(may_break, ok);
        if (!ok) return;
        repeat (3) put_byte(pick_data());
        answer_ack(may_break, ok);
        if (!ok) return;
        answer_ack(may_break, ok);
        if (!ok) return;
        if (may_break && $urandom_range(0, 29) == 0) begin
            do id_len = $urandom_range(0, 255); while (id_len == 8'd1);
            put_byte(id_len);
            return;
        end
        put_byte(8'd1);
        repeat (2) put_byte(pick_data());
        answer_ack(may_break, ok);
        if (!ok) return;
        link_up = 1'b1;
        inits_completed++;
    endtask

    task automatic run_read(logic [31:0] addr, logic [8:0] len, bit may_break);
        bit ok;
        int n;
        put_request(REQ_READ, pick_data(), addr, len);
        reads_started++;
        repeat (3) begin
            answer_ack(may_break, ok);
            if (!ok) return;
        end
        n = (len == 9'd0) ? 1 : (len > MAX_READ_BYTES_DEF) ? MAX_READ_BYTES_DEF : len;
        repeat (n) begin
            if (may_break) interject();
            put_byte(pick_data());
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    initial begin
        int r;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_NONE;
        req_ch.rx_byte     = 8'h00;
        req_ch.address     = 32'h0;
        req_ch.read_length = 9'd0;
        res_ch.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_byte(ACK_BYTE);
        put_request(REQ_NONE, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
        put_request(REQ_READ, 8'h00, 32'h0000_0000, 9'd1);
        put_request(REQ_INIT, 8'h00, 32'h0000_0000, 9'd0);
        put_request(REQ_INIT, 8'h00, 32'h0000_0000, 9'd0);
        put_request(REQ_READ, 8'h00, 32'h0000_0000, 9'd1);
        put_byte(8'h00);
        run_init(0, 1'b0);
        put_request(REQ_READ, 8'h00, 32'h0000_0003, 9'd4);
        run_read(32'hFFFF_FFFC, 9'd0, 1'b0);

        run_init(11, 1'b0);

        while (requests_sent < REQUEST_GOAL - FULL_READ_ITEMS) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            if (!hold_off_req && link_up) begin
                hold_off_req <= 1'b1;
                run_read(aligned_addr(), $urandom_range(4, 12), 1'b0);
            end else if (!drained_once) begin
                drained_once = 1'b1;
                drain_results();
            end else begin
                r = $urandom_range(0, 99);
                if (link_up && r < 55) run_read(aligned_addr(), pick_length(), 1'b1);
                else if (r < 75) run_init(pick_get_count(), 1'b1);
                else if (r < 82)
                    put_request(REQ_READ, pick_data(), misaligned_addr(), pick_length());
                else if (r < 89) put_byte(pick_data());
                else if (r < 94)
                    put_request(REQ_NONE, pick_data(), $urandom(), $urandom_range(0, 511));
                else if (!link_up)
                    put_request(REQ_READ, pick_data(), aligned_addr(), pick_length());
                else drain_results();
            end
        end

        sender_burst = 1'b0;
        if (!link_up) run_init(11, 1'b0);
        if (link_up) run_read(aligned_addr(), $urandom_range(256, 511), 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Drove %0d request items: %0d init handshakes completed, %0d reads started.",
                 requests_sent, inits_completed, reads_started);
        $display("Compared %0d result items, %0d mismatches.", results_checked, errors);
        if (errors == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
